// ----- hw/rtl/fractional_baud_divisor_calc_top_macros.svh -----
// Assertion helpers for the checker file.
`ifndef FRACTIONAL_BAUD_DIVISOR_CALC_TOP_MACROS_SVH
`define FRACTIONAL_BAUD_DIVISOR_CALC_TOP_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define FBD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define FBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/fbd_pkg.sv -----
package fbd_pkg;

  localparam int unsigned BaudW    = 32;
  localparam int unsigned ClkW     = 32;
  localparam int unsigned EffW     = 29;  // effective baud is at most clock/8
  localparam int unsigned ProdW    = 38;  // limit * baud, first limit is 255
  localparam int unsigned DivW     = 40;  // rounded dividend and divisor
  localparam int unsigned DivSteps = 40;
  localparam int unsigned CntW     = 6;
  localparam int unsigned DivisorW = 12;
  localparam int unsigned ExpW     = 4;

  // clock/8 and clock/4194304, one more halving in normal speed
  localparam int unsigned MaxShiftDs = 3;
  localparam int unsigned MaxShiftNs = 4;
  localparam int unsigned MinShiftDs = 22;
  localparam int unsigned MinShiftNs = 23;

  localparam logic signed [ExpW-1:0] ExpLow  = -4'sd7;
  localparam logic signed [ExpW-1:0] ExpHigh = 4'sd7;
  localparam logic signed [ExpW-1:0] ExpFine = -4'sd3;

  localparam logic [CntW-1:0] DivLast = CntW'(DivSteps - 1);

  localparam logic [ClkW-1:0] ClockReset = 32'd32_000_000;

  typedef enum logic {
    REG_CLOCK_HZ,
    REG_DOUBLE_SPEED
  } fbd_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SEARCH,
    ST_PREP,
    ST_DIVIDE,
    ST_FINISH
  } fbd_state_e;

  typedef struct packed {
    logic load;
    logic check;
    logic step;
    logic prep;
    logic div;
    logic finish;
  } fbd_cmd_t;

  typedef struct packed {
    logic bad;
    logic found;
    logic div_last;
  } fbd_status_t;

endpackage

// ----- hw/rtl/fbd_ctrl.sv -----
module fbd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  fbd_pkg::fbd_status_t status_i,
  output fbd_pkg::fbd_cmd_t    cmd_o
);

  fbd_pkg::fbd_state_e state_q, state_d;
  logic                out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fbd_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    case (state_q)
      fbd_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = fbd_pkg::ST_CHECK;
        end
      end
      fbd_pkg::ST_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = status_i.bad ? fbd_pkg::ST_FINISH : fbd_pkg::ST_SEARCH;
      end
      fbd_pkg::ST_SEARCH: begin
        if (status_i.found) begin
          state_d = fbd_pkg::ST_PREP;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      fbd_pkg::ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = fbd_pkg::ST_DIVIDE;
      end
      fbd_pkg::ST_DIVIDE: begin
        cmd_o.div = 1'b1;
        if (status_i.div_last) begin
          state_d = fbd_pkg::ST_FINISH;
        end
      end
      fbd_pkg::ST_FINISH: begin
        // wait for the output register to free up
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = fbd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fbd_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- hw/rtl/fbd_dpath.sv -----
module fbd_dpath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [fbd_pkg::ClkW-1:0]             clock_hz_i,
  input  logic                                 double_speed_i,
  input  logic [fbd_pkg::BaudW-1:0]            baud_rate_i,
  input  fbd_pkg::fbd_cmd_t                    cmd_i,
  output fbd_pkg::fbd_status_t                 status_o,
  output logic                                 ok_o,
  output logic [fbd_pkg::DivisorW-1:0]         divisor_o,
  output logic signed [fbd_pkg::ExpW-1:0]      scale_exp_o
);

  localparam int unsigned DivW = fbd_pkg::DivW;

  logic [fbd_pkg::BaudW-1:0]        baud_q;
  logic [fbd_pkg::EffW-1:0]         b_q;
  logic [fbd_pkg::ProdW-1:0]        prod_q;
  logic signed [fbd_pkg::ExpW-1:0]  exp_q;
  logic                             range_ok_q;
  logic [DivW-1:0]                  rem_q, dvd_q, den_q;
  logic [fbd_pkg::CntW-1:0]         cnt_q;
  logic                             ok_q;
  logic [fbd_pkg::DivisorW-1:0]     divisor_q;
  logic signed [fbd_pkg::ExpW-1:0]  scale_q;

  // range check
  logic [fbd_pkg::ClkW-1:0] rate_hi, rate_lo;
  logic                     bad;
  logic [fbd_pkg::EffW-1:0] b_eff;
  logic [fbd_pkg::ProdW-1:0] prod_init, prod_step;

  assign rate_hi = double_speed_i ? (clock_hz_i >> fbd_pkg::MaxShiftDs)
                                  : (clock_hz_i >> fbd_pkg::MaxShiftNs);
  assign rate_lo = double_speed_i ? (clock_hz_i >> fbd_pkg::MinShiftDs)
                                  : (clock_hz_i >> fbd_pkg::MinShiftNs);
  assign bad = (baud_q == '0) || (baud_q > rate_hi) || (baud_q < rate_lo);

  // normal speed works with twice the baud
  assign b_eff = double_speed_i ? baud_q[fbd_pkg::EffW-1:0]
                                : {baud_q[fbd_pkg::EffW-2:0], 1'b0};

  // limit * baud, kept incrementally: 255*b, then 2x (+b while the limit gains a one)
  assign prod_init = fbd_pkg::ProdW'({b_eff, 8'b0}) - fbd_pkg::ProdW'(b_eff);
  assign prod_step = {prod_q[fbd_pkg::ProdW-2:0], 1'b0}
                   + ((exp_q < fbd_pkg::ExpFine) ? fbd_pkg::ProdW'(b_q) : '0);

  // ratio < limit  <=>  clock < limit * baud
  assign status_o.found = (fbd_pkg::ProdW'(clock_hz_i) < prod_q) || (exp_q == fbd_pkg::ExpHigh);
  assign status_o.bad   = bad;

  // dividend and divisor of the rounded division
  logic [fbd_pkg::ClkW-1:0] diff;
  logic [2:0]               neg_sh;
  logic [3:0]               pos_sh;
  logic [DivW-1:0]          den_b, num, den, dividend;

  assign diff   = clock_hz_i - {b_q, 3'b0};
  assign neg_sh = 3'(~$unsigned(exp_q) - 4'd2);
  assign pos_sh = $unsigned(exp_q) + 4'd3;
  assign den_b  = DivW'(b_q);

  always_comb begin
    if (exp_q <= fbd_pkg::ExpFine) begin
      num = DivW'(diff) << neg_sh;
      den = den_b;
    end else if (exp_q[fbd_pkg::ExpW-1]) begin
      num = DivW'(diff);
      den = den_b << pos_sh;
    end else begin
      num = DivW'(clock_hz_i);
      den = den_b << pos_sh;
    end
  end

  assign dividend = num + (den >> 1);

  // restoring divider, one quotient bit per cycle
  logic [DivW-1:0] trial;
  logic [DivW:0]   trial_sub;
  logic            ge;

  assign trial     = {rem_q[DivW-2:0], dvd_q[DivW-1]};
  assign trial_sub = {1'b0, trial} - {1'b0, den_q};
  assign ge        = !trial_sub[DivW];

  assign status_o.div_last = (cnt_q == fbd_pkg::DivLast);

  logic [fbd_pkg::DivisorW-1:0] quo, div_val;
  assign quo     = dvd_q[fbd_pkg::DivisorW-1:0];
  assign div_val = exp_q[fbd_pkg::ExpW-1] ? quo : quo - 12'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.prep) begin
      cnt_q <= '0;
    end else if (cmd_i.div) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      baud_q <= baud_rate_i;
    end
    if (cmd_i.check) begin
      range_ok_q <= !bad;
      b_q        <= b_eff;
      prod_q     <= prod_init;
      exp_q      <= fbd_pkg::ExpLow;
    end
    if (cmd_i.step) begin
      prod_q <= prod_step;
      exp_q  <= exp_q + 4'sd1;
    end
    if (cmd_i.prep) begin
      rem_q <= '0;
      dvd_q <= dividend;
      den_q <= den;
    end
    if (cmd_i.div) begin
      rem_q <= ge ? trial_sub[DivW-1:0] : trial;
      dvd_q <= {dvd_q[DivW-2:0], ge};
    end
    if (cmd_i.finish) begin
      ok_q      <= range_ok_q;
      divisor_q <= range_ok_q ? div_val : '0;
      scale_q   <= range_ok_q ? exp_q : '0;
    end
  end

  assign ok_o        = ok_q;
  assign divisor_o   = divisor_q;
  assign scale_exp_o = scale_q;

endmodule

// ----- hw/rtl/fractional_baud_divisor_calc_top.sv -----
// Fractional baud generator setting calculator.
// Input channel (in_valid_i/in_ready_o) carries one requested baud rate per item;
// the output channel (out_valid_o/out_ready_i) returns ok, a 12-bit divisor and a
// signed scale exponent. clock_hz and double_speed sit in an APB register file
// (0x0 and 0x4); write them only while no item is in flight.
// Flow: one item at a time. After acceptance a range check runs, then the exponent
// search (one limit compare per cycle), a setup step, the restoring divider with one
// quotient bit per cycle, and a last step that loads the output register. A rejected
// rate goes from the range check straight to loading the output register. The next
// item is taken the cycle after the result is loaded, even while that result still
// waits in the output register.
// Stall: a finished item waits until the output register frees up.
// Reset: clock_hz returns to 32000000, double_speed to 0, the block goes idle and
// drops out_valid_o.
module fractional_baud_divisor_calc_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [fbd_pkg::BaudW-1:0]           baud_rate_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                ok_o,
  output logic [fbd_pkg::DivisorW-1:0]        divisor_o,
  output logic signed [fbd_pkg::ExpW-1:0]     scale_exp_o
);

  logic [fbd_pkg::ClkW-1:0] clock_hz_q, clock_hz_d;
  logic                     double_speed_q, double_speed_d;
  logic                     wr_en;
  fbd_pkg::fbd_reg_e        reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = fbd_pkg::fbd_reg_e'(paddr[2]);

  always_comb begin
    clock_hz_d     = clock_hz_q;
    double_speed_d = double_speed_q;
    if (wr_en) begin
      case (reg_sel)
        fbd_pkg::REG_CLOCK_HZ:     clock_hz_d     = pwdata;
        fbd_pkg::REG_DOUBLE_SPEED: double_speed_d = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      fbd_pkg::REG_CLOCK_HZ:     prdata = clock_hz_q;
      fbd_pkg::REG_DOUBLE_SPEED: prdata = {31'b0, double_speed_q};
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_hz_q     <= fbd_pkg::ClockReset;
      double_speed_q <= 1'b0;
    end else begin
      clock_hz_q     <= clock_hz_d;
      double_speed_q <= double_speed_d;
    end
  end

  fbd_pkg::fbd_cmd_t    cmd;
  fbd_pkg::fbd_status_t status;

  fbd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  fbd_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .clock_hz_i     (clock_hz_q),
    .double_speed_i (double_speed_q),
    .baud_rate_i    (baud_rate_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .ok_o           (ok_o),
    .divisor_o      (divisor_o),
    .scale_exp_o    (scale_exp_o)
  );

endmodule

// ----- hw/rtl/fbd_checker.sv -----
`include "fractional_baud_divisor_calc_top_macros.svh"

module fbd_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic                                ok_o,
  input logic [fbd_pkg::DivisorW-1:0]        divisor_o,
  input logic signed [fbd_pkg::ExpW-1:0]     scale_exp_o
);

  // exponent never leaves -7..7
  `FBD_ASSERT_SAME(a_scale_range, clk_i, rst_ni, out_valid_o && ok_o, scale_exp_o != 4'b1000, "scale exponent out of range")
  // rejected rates carry zero fields
  `FBD_ASSERT_SAME(a_reject_zero, clk_i, rst_ni, out_valid_o && !ok_o, (divisor_o == '0) && (scale_exp_o == '0), "rejected item with nonzero fields")
  // one item at a time
  `FBD_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o, "input ready right after accept")
  `FBD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(ok_o) && $stable(divisor_o) && $stable(scale_exp_o), "stalled result changed")

endmodule

bind fractional_baud_divisor_calc_top fbd_checker u_fbd_checker (.*);

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;

  localparam int WatchdogLimit = 5000;
  localparam int HoldCycles    = 400;
  localparam int PhaseItems    = 145;

  typedef struct packed {
    logic                              ok;
    logic [fbd_pkg::DivisorW-1:0]      divisor;
    logic signed [fbd_pkg::ExpW-1:0]   scale_exp;
  } baud_setting_t;

  // one directed item: the configuration it runs under, the rate, and an
  // optional hand-typed result (typed = 0 means use the predictor)
  typedef struct packed {
    logic [31:0]                       clk_hz;
    logic                              ds;
    logic [31:0]                       baud;
    logic                              typed;
    logic                              ok;
    logic [fbd_pkg::DivisorW-1:0]      divisor;
    logic signed [fbd_pkg::ExpW-1:0]   scale_exp;
  } rate_row_t;

  localparam int NumRows = 23;
  localparam rate_row_t RateRows [NumRows] = '{
    '{32'd32_000_000, 1'b0, 32'd0,          1'b1, 1'b0, 12'd0, 4'sb0000},
    '{32'd32_000_000, 1'b0, 32'd9600,       1'b0, 1'b0, 12'd0, 4'sb0000},
    '{32'd32_000_000, 1'b0, 32'd115200,     1'b0, 1'b0, 12'd0, 4'sb0000},
    '{32'd32_000_000, 1'b0, 32'd2_000_000,  1'b1, 1'b1, 12'd0, 4'sb1001},
    '{32'd32_000_000, 1'b0, 32'd2_000_001,  1'b1, 1'b0, 12'd0, 4'sb0000},
    '{32'd32_000_000, 1'b0, 32'd3,          1'b0, 1'b0, 12'd0, 4'sb0000},
    '{32'd32_000_000, 1'b0, 32'd2,          1'b1, 1'b0, 12'd0, 4'sb0000},
    '{32'd32_000_000, 1'b0, 32'hFFFF_FFFF,  1'b1, 1'b0, 12'd0, 4'sb0000},
    '{32'd32_000_000, 1'b1, 32'd4_000_000,  1'b1, 1'b1, 12'd0, 4'sb1001},
    '{32'd32_000_000, 1'b1, 32'd57600,      1'b0, 1'b0, 12'd0, 4'sb0000},
    '{32'd32_000_000, 1'b1, 32'd4_000_001,  1'b1, 1'b0, 12'd0, 4'sb0000},
    '{32'hFFFF_FFFF,  1'b1, 32'd536870911,  1'b0, 1'b0, 12'd0, 4'sb0000},
    '{32'hFFFF_FFFF,  1'b1, 32'd536870912,  1'b1, 1'b0, 12'd0, 4'sb0000},
    '{32'hFFFF_FFFF,  1'b1, 32'd1023,       1'b0, 1'b0, 12'd0, 4'sb0000},
    '{32'hFFFF_FFFF,  1'b1, 32'd1022,       1'b1, 1'b0, 12'd0, 4'sb0000},
    '{32'hFFFF_FFFF,  1'b0, 32'd511,        1'b0, 1'b0, 12'd0, 4'sb0000},
    '{32'hFFFF_FFFF,  1'b0, 32'd268435455,  1'b0, 1'b0, 12'd0, 4'sb0000},
    '{32'd16_777_216, 1'b1, 32'd4,          1'b0, 1'b0, 12'd0, 4'sb0000},
    '{32'd16_777_216, 1'b1, 32'd3,          1'b1, 1'b0, 12'd0, 4'sb0000},
    '{32'd1,          1'b0, 32'd1,          1'b1, 1'b0, 12'd0, 4'sb0000},
    '{32'd1,          1'b0, 32'd0,          1'b1, 1'b0, 12'd0, 4'sb0000},
    '{32'd0,          1'b1, 32'd1,          1'b1, 1'b0, 12'd0, 4'sb0000},
    '{32'd0,          1'b1, 32'hFFFF_FFFF,  1'b1, 1'b0, 12'd0, 4'sb0000}
  };

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              psel = 1'b0;
  logic                              penable = 1'b0;
  logic                              pwrite = 1'b0;
  logic [2:0]                        paddr = '0;
  logic [31:0]                       pwdata = '0;
  logic [31:0]                       prdata;
  logic                              pready;
  logic                              in_valid_i = 1'b0;
  logic                              in_ready_o;
  logic [fbd_pkg::BaudW-1:0]         baud_rate_i = '0;
  logic                              out_valid_o;
  logic                              out_ready_i = 1'b0;
  logic                              ok_o;
  logic [fbd_pkg::DivisorW-1:0]      divisor_o;
  logic signed [fbd_pkg::ExpW-1:0]   scale_exp_o;

  fractional_baud_divisor_calc_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .baud_rate_i (baud_rate_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ok_o        (ok_o),
    .divisor_o   (divisor_o),
    .scale_exp_o (scale_exp_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  baud_setting_t pending_settings[$];
  logic [31:0]   cfg_clock_hz = fbd_pkg::ClockReset;
  logic          cfg_double_speed = 1'b0;
  int            errors = 0;
  int            snd_idle_pct = 0;
  int            rcv_idle_pct = 0;
  logic          hold_req = 1'b0;
  int            hold_cnt = 0;
  int            quiet_cycles = 0;
  baud_setting_t want_s;

  function automatic baud_setting_t calc_baud_setting(logic [31:0] clk_hz, logic ds,
                                                      logic [31:0] rate);
    logic [63:0]   clk, baud, hi, lo, lim, ratio, num, den, q;
    int            e;
    baud_setting_t r;
    r = '0;
    clk = 64'(clk_hz);
    baud = 64'(rate);
    hi = clk >> 3;
    lo = clk / 64'd4194304;
    if (!ds) begin
      hi = hi >> 1;
      lo = lo >> 1;
    end
    if (baud == 0 || baud > hi || baud < lo) return r;
    if (!ds) baud = baud << 1;
    // smallest exponent whose limit exceeds clock/baud
    lim = 64'd255;
    ratio = clk / baud;
    e = -7;
    while (e < 7 && ratio >= lim) begin
      lim = lim << 1;
      if (e < -3) lim = lim | 64'd1;
      e++;
    end
    if (e < 0) begin
      num = clk - 8 * baud;
      if (e <= -3) begin
        num = num << (-e - 3);
        q = (num + baud / 2) / baud;
      end else begin
        den = baud << (e + 3);
        q = (num + den / 2) / den;
      end
    end else begin
      den = baud << (e + 3);
      q = (clk + den / 2) / den - 64'd1;
    end
    r.ok = 1'b1;
    r.divisor = q[fbd_pkg::DivisorW-1:0];
    r.scale_exp = fbd_pkg::ExpW'(e);
    return r;
  endfunction

  task automatic apb_write(fbd_pkg::fbd_reg_e r, logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // stop offering, let every result come back, then rewrite both registers
  task automatic set_config(logic [31:0] clk_hz, logic ds);
    in_valid_i <= 1'b0;
    while (pending_settings.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    apb_write(fbd_pkg::REG_CLOCK_HZ, clk_hz);
    apb_write(fbd_pkg::REG_DOUBLE_SPEED, {31'd0, ds});
    cfg_clock_hz = clk_hz;
    cfg_double_speed = ds;
  endtask

  // valid stays high across back-to-back items; within this task it drops only for a gap
  task automatic send_rate(logic [31:0] b, logic typed, baud_setting_t typed_res);
    int gap;
    gap = 0;
    while (gap < 30 && $urandom_range(99) < snd_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    baud_rate_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    if (typed) pending_settings.push_back(typed_res);
    else pending_settings.push_back(calc_baud_setting(cfg_clock_hz, cfg_double_speed, b));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_settings.size() == 0) begin
        $display("%0t: result with nothing pending: ok=%0d div=%0d exp=%0d",
                 $time, ok_o, divisor_o, scale_exp_o);
        errors++;
      end else begin
        want_s = pending_settings.pop_front();
        if (ok_o !== want_s.ok || divisor_o !== want_s.divisor ||
            scale_exp_o !== want_s.scale_exp) begin
          $display("%0t: mismatch: expected ok=%0d div=%0d exp=%0d, got ok=%0d div=%0d exp=%0d",
                   $time, want_s.ok, want_s.divisor, want_s.scale_exp,
                   ok_o, divisor_o, scale_exp_o);
          errors++;
        end
      end
    end
    if (hold_req && hold_cnt < HoldCycles) begin
      hold_cnt++;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    logic [31:0]   clk_sel, b;
    logic          ds_sel;
    logic [63:0]   lo, hi, span, v;
    baud_setting_t none_s;
    int            pick;
    none_s = '0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    snd_idle_pct = 38;
    rcv_idle_pct = 50;
    for (int i = 0; i < NumRows; i++) begin
      if (RateRows[i].clk_hz != cfg_clock_hz || RateRows[i].ds != cfg_double_speed)
        set_config(RateRows[i].clk_hz, RateRows[i].ds);
      send_rate(RateRows[i].baud, RateRows[i].typed,
                '{RateRows[i].ok, RateRows[i].divisor, RateRows[i].scale_exp});
    end

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin clk_sel = 32'hFFFF_FFFF; ds_sel = 1'b0; end
        2: begin clk_sel = 32'd1; ds_sel = 1'b1; end
        5: begin clk_sel = fbd_pkg::ClockReset; ds_sel = 1'b1; end
        default: begin
          case ($urandom_range(3))
            0: clk_sel = $urandom;
            1: clk_sel = $urandom_range(100_000_000, 1_000_000);
            2: clk_sel = 32'hFFFF_FFFF - $urandom_range(100_000);
            default: clk_sel = $urandom_range(4_000_000, 1);
          endcase
          ds_sel = $urandom_range(1);
        end
      endcase
      set_config(clk_sel, ds_sel);
      if (ph < 3) begin
        snd_idle_pct = 38;
        rcv_idle_pct = 50;
      end else if (ph < 6) begin
        snd_idle_pct = 50;
        rcv_idle_pct = 38;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      // long receiver hold-off so the block backs up onto its input
      if (ph == 4) hold_req = 1'b1;

      hi = 64'(cfg_clock_hz) >> 3;
      lo = 64'(cfg_clock_hz) / 64'd4194304;
      if (!cfg_double_speed) begin
        hi = hi >> 1;
        lo = lo >> 1;
      end
      if (lo == 0) lo = 1;
      for (int n = 0; n < PhaseItems; n++) begin
        pick = $urandom_range(99);
        if (hi < lo) pick = 90;
        if (pick < 70) begin
          span = hi - lo + 1;
          v = 64'($urandom) >> $urandom_range(31, 0);
          b = 32'(lo + v % span);
        end else if (pick < 82) begin
          case ($urandom_range(5))
            0: b = 32'(lo);
            1: b = 32'(lo - 1);
            2: b = 32'(lo + 1);
            3: b = 32'(hi);
            4: b = 32'(hi - 1);
            default: b = 32'(hi + 1);
          endcase
        end else if (pick < 96) begin
          b = $urandom;
        end else begin
          b = 32'd0;
        end
        send_rate(b, 1'b0, none_s);
      end
    end

    in_valid_i <= 1'b0;
    while (pending_settings.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (pending_settings.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_settings.size());
      errors++;
    end
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
